@@ hw/rtl/cbvf_pkg.sv @@
// Shared types and constants for the cone-beam voxel footprint projector.
// No dependencies; used by every module of the block.
package cbvf_pkg;

    localparam int QW      = 41;   // quotient bits, saturation at 2**40
    localparam int NCH_W   = 112;  // channel numerator width
    localparam int DCH_W   = 96;   // channel denominator width
    localparam int NROW_W  = 76;   // row numerator width
    localparam int DROW_W  = 64;   // row denominator width
    localparam int DET_W   = 44;   // signed detector position, Q28.16

    localparam logic [2:0] REG_SRC_ISO    = 3'd0;
    localparam logic [2:0] REG_SRC_DET    = 3'd1;
    localparam logic [2:0] REG_VOX_PITCH  = 3'd2;
    localparam logic [2:0] REG_CH_PITCH   = 3'd3;
    localparam logic [2:0] REG_ROW_PITCH  = 3'd4;
    localparam logic [2:0] REG_CH_OFFSET  = 3'd5;
    localparam logic [2:0] REG_ROW_OFFSET = 3'd6;

    typedef struct packed {
        logic [17:0]        pixel_index;
        logic [7:0]         slice_index;
        logic signed [15:0] cos_theta;
        logic signed [15:0] sin_theta;
        logic               mode;
        logic               last_voxel;
    } t_in;

    typedef struct packed {
        logic [9:0]  det_row;
        logic [9:0]  det_channel;
        logic [31:0] coefficient;
        logic        tap_valid;
        logic        last_tap;
        logic        view_done;
    } t_out;

    typedef struct packed {
        logic [31:0]        source_to_iso_distance;
        logic [31:0]        source_to_detector_distance;
        logic [31:0]        voxel_pitch;
        logic [31:0]        channel_pitch;
        logic [31:0]        row_pitch;
        logic signed [31:0] channel_offset;
        logic signed [31:0] row_offset;
    } t_cfg;

    // Divider operands produced by the geometry front end.
    typedef struct packed {
        logic [NCH_W-1:0]  nch;
        logic [DCH_W-1:0]  dch;
        logic [NROW_W-1:0] nrow;
        logic [DROW_W-1:0] drow;
        logic              neg_ch;
        logic              neg_row;
        logic              mode;
        logic              last;
    } t_div_in;

    // Divider results handed to the tap generator.
    typedef struct packed {
        logic [QW-1:0] q_ch;
        logic          rnz_ch;
        logic          sat_ch;
        logic [QW-1:0] q_row;
        logic          rnz_row;
        logic          sat_row;
        logic          neg_ch;
        logic          neg_row;
        logic          mode;
        logic          last;
    } t_div_out;

endpackage

@@ hw/rtl/cbvf_front.sv @@
// Geometry front end: voxel decode, rotation, depth and divider operands.
// Depends on cbvf_pkg; eight register stages under a shared enable.
module cbvf_front #(
    parameter int GRID_SIZE   = 512,
    parameter int GRID_SLICES = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  cbvf_pkg::t_in     i_data,
    input  cbvf_pkg::t_cfg    i_cfg,
    output logic              o_valid,
    output cbvf_pkg::t_div_in o_div
);
    // Exact reciprocal for 18-bit indices and grids up to 4096.
    localparam logic [63:0] RECIP = ((64'd1 << 36) + 64'(GRID_SIZE) - 64'd1) / 64'(GRID_SIZE);
    localparam logic signed [18:0] GOFF = 19'(GRID_SIZE - 1);
    localparam logic signed [13:0] SOFF = 14'(GRID_SLICES - 1);

    logic [7:0] r_v;

    // Stage 1
    logic [63:0]   w_rprod;
    cbvf_pkg::t_in r1_d;
    logic [15:0]   r1_row;
    // Stage 2
    logic [31:0]        w_rowg;
    logic [17:0]        w_colw;
    logic signed [18:0] r2_a, r2_b;
    logic signed [13:0] r2_e;
    logic signed [15:0] r2_c, r2_s;
    logic               r2_mode, r2_last;
    // Stage 3
    logic signed [34:0] r3_ac, r3_bs, r3_bc, r3_as;
    logic [12:0]        w_mage;
    logic [31:0]        w_r;
    logic [44:0]        r3_er;
    logic               r3_se, r3_mode, r3_last;
    // Stage 4
    logic signed [35:0] w_ar, w_br;
    logic [35:0]        r4_mar, r4_mbr;
    logic               r4_sar, r4_sbr;
    logic [44:0]        r4_er;
    logic               r4_se, r4_mode, r4_last;
    // Stage 5
    logic [67:0] w_px, w_pb;
    logic [63:0] r5_magx, r5_prod;
    logic        r5_sar, r5_sbr;
    logic [44:0] r5_er;
    logic        r5_se, r5_mode, r5_last;
    // Stage 6
    logic [63:0] w_base, n_magt;
    logic        n_negt;
    logic [63:0] r6_magt, r6_pxlo, r6_pxhi;
    logic        r6_negt, r6_sar;
    logic [44:0] r6_er;
    logic        r6_se, r6_mode, r6_last;
    // Stage 7
    logic [31:0] w_cp;
    logic [95:0] w_nsum;
    logic [cbvf_pkg::NCH_W-1:0]  r7_nch;
    logic [cbvf_pkg::NROW_W-1:0] r7_nrow;
    logic [63:0] r7_magt, r7_ptlo, r7_pthi;
    logic        r7_negch, r7_negrow, r7_mode, r7_last;
    // Stage 8
    cbvf_pkg::t_div_in r8_div;

    assign w_rprod = 64'(i_data.pixel_index) * RECIP;
    assign w_rowg  = 32'(r1_row) * 32'(GRID_SIZE);
    assign w_colw  = r1_d.pixel_index - w_rowg[17:0];
    assign w_mage  = r2_e[13] ? 13'(-r2_e) : r2_e[12:0];
    assign w_r     = (i_cfg.source_to_iso_distance != 32'd0) ?
                     i_cfg.source_to_iso_distance : i_cfg.source_to_detector_distance;
    assign w_ar    = 36'(r3_ac) + 36'(r3_bs);
    assign w_br    = 36'(r3_bc) - 36'(r3_as);
    assign w_px    = {32'd0, r4_mar} * {36'd0, i_cfg.voxel_pitch};
    assign w_pb    = {32'd0, r4_mbr} * {36'd0, i_cfg.voxel_pitch};
    assign w_base  = {16'd0, i_cfg.source_to_iso_distance, 16'd0};
    assign w_cp    = (i_cfg.channel_pitch != 32'd0) ? i_cfg.channel_pitch : 32'd1;
    assign w_nsum  = {r6_pxhi, 32'd0} + {32'd0, r6_pxlo};

    // Source depth with its sign; a zero depth becomes one positive LSB.
    always_comb begin
        n_negt = 1'b0;
        if (!r5_sbr) begin
            n_magt = w_base + r5_prod;
        end else if (r5_prod > w_base) begin
            n_magt = r5_prod - w_base;
            n_negt = 1'b1;
        end else begin
            n_magt = w_base - r5_prod;
        end
        if (n_magt == 64'd0) begin
            n_magt = 64'd1;
            n_negt = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[6:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_d      <= i_data;
            r1_row    <= w_rprod[51:36];

            r2_a      <= $signed({5'd0, w_colw[12:0], 1'b0}) - GOFF;
            r2_b      <= $signed({2'd0, r1_row, 1'b0}) - GOFF;
            r2_e      <= $signed({5'd0, r1_d.slice_index, 1'b0}) - SOFF;
            r2_c      <= r1_d.cos_theta;
            r2_s      <= r1_d.sin_theta;
            r2_mode   <= r1_d.mode;
            r2_last   <= r1_d.last_voxel;

            r3_ac     <= 35'(r2_a) * 35'(r2_c);
            r3_bs     <= 35'(r2_b) * 35'(r2_s);
            r3_bc     <= 35'(r2_b) * 35'(r2_c);
            r3_as     <= 35'(r2_a) * 35'(r2_s);
            r3_er     <= {32'd0, w_mage} * {13'd0, w_r};
            r3_se     <= r2_e[13];
            r3_mode   <= r2_mode;
            r3_last   <= r2_last;

            r4_mar    <= w_ar[35] ? 36'(-w_ar) : 36'(w_ar);
            r4_mbr    <= w_br[35] ? 36'(-w_br) : 36'(w_br);
            r4_sar    <= w_ar[35];
            r4_sbr    <= w_br[35];
            r4_er     <= r3_er;
            r4_se     <= r3_se;
            r4_mode   <= r3_mode;
            r4_last   <= r3_last;

            r5_magx   <= w_px[63:0];
            r5_prod   <= w_pb[63:0];
            r5_sar    <= r4_sar;
            r5_sbr    <= r4_sbr;
            r5_er     <= r4_er;
            r5_se     <= r4_se;
            r5_mode   <= r4_mode;
            r5_last   <= r4_last;

            r6_magt   <= n_magt;
            r6_negt   <= n_negt;
            r6_pxlo   <= 64'(r5_magx[31:0]) * 64'(i_cfg.source_to_detector_distance);
            r6_pxhi   <= 64'(r5_magx[63:32]) * 64'(i_cfg.source_to_detector_distance);
            r6_sar    <= r5_sar;
            r6_er     <= r5_er;
            r6_se     <= r5_se;
            r6_mode   <= r5_mode;
            r6_last   <= r5_last;

            r7_nch    <= {w_nsum, 16'd0};
            r7_nrow   <= {r6_er, 31'd0};
            r7_magt   <= r6_magt;
            r7_ptlo   <= 64'(r6_magt[31:0]) * 64'(w_cp);
            r7_pthi   <= 64'(r6_magt[63:32]) * 64'(w_cp);
            r7_negch  <= r6_sar ^ r6_negt;
            r7_negrow <= r6_se ^ r6_negt;
            r7_mode   <= r6_mode;
            r7_last   <= r6_last;

            r8_div.nch     <= r7_nch;
            r8_div.dch     <= {r7_pthi, 32'd0} + {32'd0, r7_ptlo};
            r8_div.nrow    <= r7_nrow;
            r8_div.drow    <= r7_magt;
            r8_div.neg_ch  <= r7_negch;
            r8_div.neg_row <= r7_negrow;
            r8_div.mode    <= r7_mode;
            r8_div.last    <= r7_last;
        end
    end

    assign o_valid = r_v[7];
    assign o_div   = r8_div;

endmodule

@@ hw/rtl/cbvf_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, with saturation.
// Depends on cbvf_pkg for the quotient width.
module cbvf_div #(
    parameter int NW = 112,
    parameter int DW = 96,
    parameter int SW = 3
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic [NW-1:0]          i_n,
    input  logic [DW-1:0]          i_d,
    input  logic [SW-1:0]          i_side,
    output logic                   o_valid,
    output logic [cbvf_pkg::QW-1:0] o_q,
    output logic                   o_rem_nz,
    output logic                   o_sat,
    output logic [SW-1:0]          o_side
);
    localparam int QW = cbvf_pkg::QW;
    localparam int W  = ((NW > DW + QW) ? NW : DW + QW) + 1;

    logic [QW:0]    r_v;
    logic [W-1:0]   r_r    [0:QW];
    logic [DW-1:0]  r_d    [0:QW];
    logic [QW-1:0]  r_q    [0:QW];
    logic           r_sat  [0:QW];
    logic [SW-1:0]  r_side [0:QW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[QW-1:0], i_valid};
        end
    end

    // A quotient of 2**41 or more is flagged up front as saturated.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_r[0]    <= W'(i_n);
            r_d[0]    <= i_d;
            r_q[0]    <= '0;
            r_sat[0]  <= W'(i_n) >= (W'(i_d) << QW);
            r_side[0] <= i_side;
        end
    end

    for (genvar j = 1; j <= QW; j++) begin : g_step
        localparam int SH = QW - j;
        logic [W-1:0] w_dsh;
        logic         w_ge;
        assign w_dsh = W'(r_d[j-1]) << SH;
        assign w_ge  = r_r[j-1] >= w_dsh;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_r[j]    <= w_ge ? (r_r[j-1] - w_dsh) : r_r[j-1];
                r_q[j]    <= r_q[j-1] | (w_ge ? (QW'(1) << SH) : '0);
                r_d[j]    <= r_d[j-1];
                r_sat[j]  <= r_sat[j-1];
                r_side[j] <= r_side[j-1];
            end
        end
    end

    assign o_valid  = r_v[QW];
    assign o_q      = r_q[QW];
    assign o_rem_nz = |r_r[QW];
    assign o_sat    = r_sat[QW];
    assign o_side   = r_side[QW];

endmodule

@@ hw/rtl/cbvf_taps.sv @@
// Tap generator: detector positions, bilinear weights and coefficients.
// Depends on cbvf_pkg; four register stages under a shared enable.
module cbvf_taps #(
    parameter int DETECTOR_ROWS     = 1024,
    parameter int DETECTOR_CHANNELS = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  cbvf_pkg::t_div_out       i_div,
    input  cbvf_pkg::t_cfg           i_cfg,
    output logic                     o_valid,
    output cbvf_pkg::t_out [3:0]     o_taps
);
    localparam int DW = cbvf_pkg::DET_W;
    localparam logic [cbvf_pkg::QW-1:0] QLIM = cbvf_pkg::QW'(1) << (cbvf_pkg::QW - 1);
    localparam logic signed [DW-1:0] CH_CTR  = DW'(longint'(DETECTOR_CHANNELS - 1) * 32768);
    localparam logic signed [DW-1:0] ROW_CTR = DW'(longint'(DETECTOR_ROWS - 1) * 32768);
    localparam logic signed [28:0] ROW_LIM = 29'(DETECTOR_ROWS);
    localparam logic signed [28:0] CH_LIM  = 29'(DETECTOR_CHANNELS);

    function automatic logic signed [DW-1:0] f_quot(
        input logic [cbvf_pkg::QW-1:0] q,
        input logic                    sat,
        input logic                    rnz,
        input logic                    neg
    );
        logic [cbvf_pkg::QW-1:0] qm;
        logic signed [DW-1:0]    m;
        qm = (sat || (q > QLIM)) ? QLIM : q;
        m  = $signed(DW'(qm));
        f_quot = neg ? (-m - DW'(rnz)) : m;
    endfunction

    logic [3:0] r_v;

    logic signed [DW-1:0] r1_ch, r1_row;
    logic                 r1_mode, r1_last;

    logic signed [27:0] w_ic, w_ir;
    logic [32:0] r2_w [4];
    logic [9:0]  r2_r [4];
    logic [9:0]  r2_c [4];
    logic [3:0]  r2_ok;
    logic        r2_mode, r2_last;

    logic [64:0] w_cw [4];
    logic [31:0] r3_coef [4];
    logic [9:0]  r3_r [4];
    logic [9:0]  r3_c [4];
    logic [3:0]  r3_ok;
    logic        r3_mode, r3_last;

    logic [63:0] w_sq [4];
    cbvf_pkg::t_out [3:0] r4_taps;

    assign w_ic = r1_ch[DW-1:16];
    assign w_ir = r1_row[DW-1:16];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_ch   <= f_quot(i_div.q_ch, i_div.sat_ch, i_div.rnz_ch, i_div.neg_ch)
                       + CH_CTR + DW'(i_cfg.channel_offset);
            r1_row  <= f_quot(i_div.q_row, i_div.sat_row, i_div.rnz_row, i_div.neg_row)
                       + ROW_CTR + DW'(i_cfg.row_offset);
            r1_mode <= i_div.mode;
            r1_last <= i_div.last;
            r2_mode <= r1_mode;
            r2_last <= r1_last;
            r3_ok   <= r2_ok;
            r3_mode <= r2_mode;
            r3_last <= r2_last;
        end
    end

    // Taps in order: (r0,c0), (r0,c0+1), (r0+1,c0), (r0+1,c0+1).
    for (genvar k = 0; k < 4; k++) begin : g_tap
        localparam logic DR = k[1];
        localparam logic DC = k[0];
        logic signed [28:0] w_ri, w_ci;
        logic [16:0]        w_wr, w_wc;
        logic [47:0]        w_sh;
        logic [31:0]        w_mc;
        assign w_ri = 29'(w_ir) + 29'(DR);
        assign w_ci = 29'(w_ic) + 29'(DC);
        assign w_wr = DR ? {1'b0, r1_row[15:0]} : (17'h10000 - {1'b0, r1_row[15:0]});
        assign w_wc = DC ? {1'b0, r1_ch[15:0]} : (17'h10000 - {1'b0, r1_ch[15:0]});
        assign w_cw[k] = {32'd0, r2_w[k]} * {33'd0, i_cfg.voxel_pitch};
        assign w_sq[k] = 64'(r3_coef[k]) * 64'(r3_coef[k]);
        assign w_sh = w_sq[k][63:16];
        assign w_mc = r3_mode ? ((w_sh[47:32] != 16'd0) ? 32'hFFFF_FFFF : w_sh[31:0])
                              : r3_coef[k];
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r2_w[k]  <= 33'(w_wr) * 33'(w_wc);
                r2_r[k]  <= w_ri[9:0];
                r2_c[k]  <= w_ci[9:0];
                r2_ok[k] <= (w_ri >= 29'sd0) && (w_ri < ROW_LIM) &&
                            (w_ci >= 29'sd0) && (w_ci < CH_LIM);
                r3_coef[k] <= w_cw[k][63:32];
                r3_r[k]    <= r2_r[k];
                r3_c[k]    <= r2_c[k];
                r4_taps[k].det_row     <= r3_ok[k] ? r3_r[k] : 10'd0;
                r4_taps[k].det_channel <= r3_ok[k] ? r3_c[k] : 10'd0;
                r4_taps[k].coefficient <= r3_ok[k] ? w_mc : 32'd0;
                r4_taps[k].tap_valid   <= r3_ok[k];
                r4_taps[k].last_tap    <= (k == 3);
                r4_taps[k].view_done   <= (k == 3) ? r3_last : 1'b0;
            end
        end
    end

    assign o_valid = r_v[3];
    assign o_taps  = r4_taps;

endmodule

@@ hw/rtl/cone_beam_voxel_footprint.sv @@
// A voxel's four taps leave the hold register one per cycle unless stalled. A
// voxel may be taken every cycle while the pipeline has room; once the hold
// register is full, the pipeline advances only as the fourth tap leaves.
// Synchronous active-low reset clears valid bits and loads register defaults.
// Depends on cbvf_pkg, cbvf_front, cbvf_div, cbvf_taps.
module cone_beam_voxel_footprint #(
    parameter int GRID_SIZE         = 512,
    parameter int GRID_SLICES       = 256,
    parameter int DETECTOR_ROWS     = 1024,
    parameter int DETECTOR_CHANNELS = 1024
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  cbvf_pkg::t_in  i_data,
    output logic           o_stall,
    output logic           o_valid,
    output cbvf_pkg::t_out o_data,
    input  logic           i_stall,
    input  logic           i_cfg_we,
    input  logic [2:0]     i_cfg_idx,
    input  logic [31:0]    i_cfg_data
);
    cbvf_pkg::t_cfg       r_cfg;
    logic                 w_en;
    logic                 w_front_v;
    cbvf_pkg::t_div_in    w_div_in;
    cbvf_pkg::t_div_out   w_div_out;
    logic                 w_div_v;
    logic [2:0]           w_side_ch;
    logic                 w_taps_v;
    cbvf_pkg::t_out [3:0] w_taps;
    cbvf_pkg::t_out [3:0] r_hold;
    logic                 r_sv;
    logic [1:0]           r_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.source_to_iso_distance      <= 32'h0001_0000;
            r_cfg.source_to_detector_distance <= 32'h0001_0000;
            r_cfg.voxel_pitch                 <= 32'h0001_0000;
            r_cfg.channel_pitch               <= 32'h0001_0000;
            r_cfg.row_pitch                   <= 32'h0001_0000;
            r_cfg.channel_offset              <= '0;
            r_cfg.row_offset                  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                cbvf_pkg::REG_SRC_ISO:    r_cfg.source_to_iso_distance      <= i_cfg_data;
                cbvf_pkg::REG_SRC_DET:    r_cfg.source_to_detector_distance <= i_cfg_data;
                cbvf_pkg::REG_VOX_PITCH:  r_cfg.voxel_pitch                 <= i_cfg_data;
                cbvf_pkg::REG_CH_PITCH:   r_cfg.channel_pitch               <= i_cfg_data;
                cbvf_pkg::REG_ROW_PITCH:  r_cfg.row_pitch                   <= i_cfg_data;
                cbvf_pkg::REG_CH_OFFSET:  r_cfg.channel_offset              <= i_cfg_data;
                cbvf_pkg::REG_ROW_OFFSET: r_cfg.row_offset                  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The whole pipeline advances when the tap register is free or hands
    // off its fourth tap in this cycle.
    assign w_en    = !r_sv || (!i_stall && (r_k == 2'd3));
    assign o_stall = !w_en;

    cbvf_front #(
        .GRID_SIZE   (GRID_SIZE),
        .GRID_SLICES (GRID_SLICES)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_data  (i_data),
        .i_cfg   (r_cfg),
        .o_valid (w_front_v),
        .o_div   (w_div_in)
    );

    cbvf_div #(
        .NW (cbvf_pkg::NCH_W),
        .DW (cbvf_pkg::DCH_W),
        .SW (3)
    ) u_div_ch (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (w_front_v),
        .i_n      (w_div_in.nch),
        .i_d      (w_div_in.dch),
        .i_side   ({w_div_in.neg_ch, w_div_in.mode, w_div_in.last}),
        .o_valid  (w_div_v),
        .o_q      (w_div_out.q_ch),
        .o_rem_nz (w_div_out.rnz_ch),
        .o_sat    (w_div_out.sat_ch),
        .o_side   (w_side_ch)
    );

    cbvf_div #(
        .NW (cbvf_pkg::NROW_W),
        .DW (cbvf_pkg::DROW_W),
        .SW (1)
    ) u_div_row (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (w_front_v),
        .i_n      (w_div_in.nrow),
        .i_d      (w_div_in.drow),
        .i_side   (w_div_in.neg_row),
        .o_valid  (),
        .o_q      (w_div_out.q_row),
        .o_rem_nz (w_div_out.rnz_row),
        .o_sat    (w_div_out.sat_row),
        .o_side   (w_div_out.neg_row)
    );

    assign w_div_out.neg_ch = w_side_ch[2];
    assign w_div_out.mode   = w_side_ch[1];
    assign w_div_out.last   = w_side_ch[0];

    cbvf_taps #(
        .DETECTOR_ROWS     (DETECTOR_ROWS),
        .DETECTOR_CHANNELS (DETECTOR_CHANNELS)
    ) u_taps (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_div_v),
        .i_div   (w_div_out),
        .i_cfg   (r_cfg),
        .o_valid (w_taps_v),
        .o_taps  (w_taps)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv <= 1'b0;
            r_k  <= 2'd0;
        end else if (w_en) begin
            r_sv <= w_taps_v;
            r_k  <= 2'd0;
        end else if (!i_stall) begin
            r_k <= r_k + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_hold <= w_taps;
        end
    end

    assign o_valid = r_sv;
    assign o_data  = r_hold[r_k];

endmodule
